// ===== design/lz77_history_copy_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// LZ77 history-copy decoder assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef LZ77_HISTORY_COPY_DECODER_ASSERT_SVH
`define LZ77_HISTORY_COPY_DECODER_ASSERT_SVH

// Same-cycle implication.
`define LZ77HC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LZ77HC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lz77hc_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ77 history-copy decoder package
// Word types, code and status constants and parameter defaults.
// ----------------------------------------------------------------------------
package lz77hc_pkg;

    localparam int WINDOW_SIZE_DEF      = 32768;
    localparam int MAX_LENGTH_DEF       = 258;
    localparam int BYTES_PER_RESULT_DEF = 8;

    localparam int LEN_W   = 9;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 3;
    localparam int DATA_W  = 64;

    localparam logic [1:0] MODE_LIT  = 2'd0;
    localparam logic [1:0] MODE_LEN  = 2'd1;
    localparam logic [1:0] MODE_DIST = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_DIST  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_STRAY    = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_TOO_FAR  = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
    } code_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] byte_count;
        logic [STAT_W-1:0]  status;
        logic               last;
    } result_word_t;

    // One element handed from the controller to the packer.
    typedef struct packed {
        logic              valid;
        logic              is_err;
        logic [STAT_W-1:0] status;
        logic [7:0]        data;
        logic              last;
    } push_t;

    // Packer fill state seen by the controller.
    typedef struct packed {
        logic               full;
        logic [COUNT_W-1:0] count;
    } pack_credit_t;

endpackage

// ===== design/lz77hc_hist_ram.sv =====
// ----------------------------------------------------------------------------
// LZ77 history RAM
// One write and one read port, registered read, write data bypassed to a
// read of the same address in the same cycle.
// ----------------------------------------------------------------------------
module lz77hc_hist_ram #(
    parameter int DEPTH = lz77hc_pkg::WINDOW_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lz77hc_packer.sv =====
// ----------------------------------------------------------------------------
// LZ77 result packer
// Gathers bytes into result words, passes error words, and holds the
// output register toward the receiver.
// ----------------------------------------------------------------------------
module lz77hc_packer #(
    parameter int BYTES_PER_RESULT = lz77hc_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lz77hc_pkg::push_t        push,
    output lz77hc_pkg::pack_credit_t credit,
    output logic                     result_valid,
    input  logic                     result_stall,
    output lz77hc_pkg::result_word_t result
);

    localparam int CW = lz77hc_pkg::COUNT_W;

    logic [lz77hc_pkg::DATA_W-1:0] acc_data_reg, acc_data_next;
    logic [CW-1:0]                 acc_count_reg, acc_count_next;
    logic [lz77hc_pkg::STAT_W-1:0] acc_status_reg, acc_status_next;
    logic                          acc_last_reg, acc_last_next;
    logic                          acc_full_reg, acc_full_next;
    lz77hc_pkg::result_word_t      out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    lz77hc_pkg::result_word_t merged;
    logic                     merged_go;
    logic                     out_free;

    always_comb
    begin
        merged = '0;
        merged_go = 1'b0;
        if (push.is_err)
        begin
            merged.status = push.status;
            merged.last = push.last;
            merged_go = 1'b1;
        end
        else
        begin
            merged.data = acc_data_reg;
            for (int i = 0; i < BYTES_PER_RESULT; i++)
            begin
                if (acc_count_reg == CW'(i))
                begin
                    merged.data[8*i +: 8] = push.data;
                end
            end
            merged.byte_count = acc_count_reg + CW'(1);
            merged.status = lz77hc_pkg::STATUS_OK;
            merged.last = push.last;
            merged_go = push.last || (merged.byte_count == CW'(BYTES_PER_RESULT));
        end
    end

    always_comb
    begin
        out_free = !out_valid_reg || !result_stall;
        acc_data_next = acc_data_reg;
        acc_count_next = acc_count_reg;
        acc_status_next = acc_status_reg;
        acc_last_next = acc_last_reg;
        acc_full_next = acc_full_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (acc_full_reg)
        begin
            if (out_free)
            begin
                out_next.data = acc_data_reg;
                out_next.byte_count = acc_count_reg;
                out_next.status = acc_status_reg;
                out_next.last = acc_last_reg;
                out_valid_next = 1'b1;
                acc_data_next = '0;
                acc_count_next = '0;
                acc_full_next = 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (merged_go && out_free)
            begin
                out_next = merged;
                out_valid_next = 1'b1;
                acc_data_next = '0;
                acc_count_next = '0;
            end
            else
            begin
                acc_data_next = merged.data;
                acc_count_next = merged.byte_count;
                acc_status_next = merged.status;
                acc_last_next = merged.last;
                acc_full_next = merged_go;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_data_reg <= '0;
            acc_count_reg <= '0;
            acc_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_data_reg <= acc_data_next;
            acc_count_reg <= acc_count_next;
            acc_full_reg <= acc_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_status_reg <= acc_status_next;
        acc_last_reg <= acc_last_next;
        out_reg <= out_next;
    end

    assign credit.full = acc_full_reg;
    assign credit.count = acc_count_reg;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule

// ===== design/lz77hc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LZ77 decode controller
// Decodes each code, keeps the window pointers and pending length, and
// drives the history RAM and the packer during literal and copy work.
// ----------------------------------------------------------------------------
module lz77hc_ctrl #(
    parameter int WINDOW_SIZE      = lz77hc_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_LENGTH       = lz77hc_pkg::MAX_LENGTH_DEF,
    parameter int BYTES_PER_RESULT = lz77hc_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           code_valid,
    input  lz77hc_pkg::code_word_t         code,
    output logic                           code_stall,
    input  lz77hc_pkg::pack_credit_t       credit,
    output lz77hc_pkg::push_t              push,
    output logic                           ram_we,
    output logic [$clog2(WINDOW_SIZE)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(WINDOW_SIZE)-1:0] ram_raddr,
    input  logic [7:0]                     ram_rdata
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int BPW = $clog2(WINDOW_SIZE + 1);
    localparam int LW  = lz77hc_pkg::LEN_W;
    localparam logic [AW-1:0]  WP_LAST = AW'(WINDOW_SIZE - 1);
    localparam logic [BPW-1:0] BP_MAX  = BPW'(WINDOW_SIZE);
    localparam logic [AW:0]    WIN_EXT = (AW+1)'(WINDOW_SIZE);

    typedef enum logic [2:0] {S_IDLE, S_PRE, S_LIT, S_ERR, S_COPY} state_t;

    state_t                        state_reg, state_next;
    state_t                        follow_reg, follow_next;
    logic [7:0]                    lit_reg, lit_next;
    logic [lz77hc_pkg::STAT_W-1:0] err_status_reg, err_status_next;
    logic                          pre_last_reg, pre_last_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [BPW-1:0]                bp_reg, bp_next;
    logic [LW-1:0]                 plen_reg, plen_next;
    logic                          lp_reg, lp_next;
    logic [AW-1:0]                 src_reg, src_next;
    logic [LW-1:0]                 remain_reg, remain_next;
    logic                          inflight_reg, inflight_next;
    logic                          inflight_last_reg, inflight_last_next;

    logic [AW:0]    dist_ext;
    logic [AW:0]    diff;
    logic [AW-1:0]  src_calc;
    logic           credit_ok;
    logic           advance;
    logic           too_far;

    always_comb
    begin
        dist_ext = code.value[AW:0];
        diff = {1'b0, wp_reg} - dist_ext;
        src_calc = ({1'b0, wp_reg} < dist_ext) ? AW'(diff + WIN_EXT) : AW'(diff);
        too_far = (code.value == 16'd0) || (code.value > 16'(bp_reg));
        // Room for the byte arriving now and for one more read issued now.
        credit_ok = !credit.full
            && ((5'(credit.count) + 5'(inflight_reg)) < 5'(BYTES_PER_RESULT));
    end

    always_comb
    begin
        state_next = state_reg;
        follow_next = follow_reg;
        lit_next = lit_reg;
        err_status_next = err_status_reg;
        pre_last_next = pre_last_reg;
        wp_next = wp_reg;
        bp_next = bp_reg;
        plen_next = plen_reg;
        lp_next = lp_reg;
        src_next = src_reg;
        remain_next = remain_reg;
        inflight_next = 1'b0;
        inflight_last_next = inflight_last_reg;
        push = '0;
        ram_we = 1'b0;
        ram_wdata = lit_reg;
        ram_re = 1'b0;
        advance = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (code_valid)
                begin
                    lit_next = code.value[7:0];
                    case (code.mode) inside
                        lz77hc_pkg::MODE_DIST:
                        begin
                            lp_next = 1'b0;
                            plen_next = '0;
                            if (!lp_reg)
                            begin
                                err_status_next = lz77hc_pkg::STATUS_STRAY;
                                state_next = S_ERR;
                            end
                            else if (too_far)
                            begin
                                err_status_next = lz77hc_pkg::STATUS_TOO_FAR;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                src_next = src_calc;
                                remain_next = plen_reg;
                                state_next = (plen_reg == '0) ? S_IDLE : S_COPY;
                            end
                        end
                        lz77hc_pkg::MODE_LIT, lz77hc_pkg::MODE_LEN:
                        begin
                            // A pending length without its distance is dropped first.
                            if (lp_reg)
                            begin
                                lp_next = 1'b0;
                                plen_next = '0;
                            end
                            if (code.mode == lz77hc_pkg::MODE_LIT)
                            begin
                                follow_next = S_LIT;
                            end
                            else if (code.value > 16'(MAX_LENGTH))
                            begin
                                err_status_next = lz77hc_pkg::STATUS_TOO_LONG;
                                follow_next = S_ERR;
                            end
                            else
                            begin
                                plen_next = code.value[LW-1:0];
                                lp_next = 1'b1;
                                follow_next = S_IDLE;
                            end
                            pre_last_next = (follow_next == S_IDLE);
                            state_next = lp_reg ? S_PRE : follow_next;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PRE:
            begin
                if (!credit.full)
                begin
                    push.valid = 1'b1;
                    push.is_err = 1'b1;
                    push.status = lz77hc_pkg::STATUS_NO_DIST;
                    push.last = pre_last_reg;
                    state_next = follow_reg;
                end
            end
            S_LIT:
            begin
                if (!credit.full)
                begin
                    push.valid = 1'b1;
                    push.status = lz77hc_pkg::STATUS_OK;
                    push.data = lit_reg;
                    push.last = 1'b1;
                    ram_we = 1'b1;
                    advance = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (!credit.full)
                begin
                    push.valid = 1'b1;
                    push.is_err = 1'b1;
                    push.status = err_status_reg;
                    push.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                if ((remain_reg != '0) && credit_ok)
                begin
                    ram_re = 1'b1;
                    src_next = (src_reg == WP_LAST) ? '0 : src_reg + AW'(1);
                    remain_next = remain_reg - LW'(1);
                    inflight_next = 1'b1;
                    inflight_last_next = (remain_reg == LW'(1));
                end
                if (inflight_reg)
                begin
                    push.valid = 1'b1;
                    push.status = lz77hc_pkg::STATUS_OK;
                    push.data = ram_rdata;
                    push.last = inflight_last_reg;
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    advance = 1'b1;
                end
                if ((remain_reg == '0) && !inflight_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
            if (bp_reg != BP_MAX)
            begin
                bp_next = bp_reg + BPW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            follow_reg <= S_IDLE;
            wp_reg <= '0;
            bp_reg <= '0;
            plen_reg <= '0;
            lp_reg <= 1'b0;
            remain_reg <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            follow_reg <= follow_next;
            wp_reg <= wp_next;
            bp_reg <= bp_next;
            plen_reg <= plen_next;
            lp_reg <= lp_next;
            remain_reg <= remain_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg <= lit_next;
        err_status_reg <= err_status_next;
        pre_last_reg <= pre_last_next;
        src_reg <= src_next;
        inflight_last_reg <= inflight_last_next;
    end

    assign code_stall = (state_reg != S_IDLE);
    assign ram_waddr = wp_reg;
    assign ram_raddr = src_reg;

endmodule

// ===== design/lz77_history_copy_decoder.sv =====
// ----------------------------------------------------------------------------
// LZ77 history-copy decoder
// Turns literal, length and distance codes into packed output bytes.
// ----------------------------------------------------------------------------
// The code channel (code_valid, code_stall, code) carries one code word per
// handshake: a mode and a value. The result channel (result_valid,
// result_stall, result) carries up to BYTES_PER_RESULT bytes per word, with
// a byte count, a status and a last mark on the final word of each code.
// A length code gives no word. A literal passes through the literal state
// and its word is then registered in the output register. A copy reads
// one byte per cycle from the history RAM through its single read port
// while the packer has room; a byte still being written when it is read
// is bypassed from the write port, and one read is skipped each time the
// packer closes a full word. A copy of zero bytes gives no word.
// A dropped length is reported by an error word of its own first.
// Codes are taken one at a time; code_stall is high while a code is worked.
// Reset clears the pointers and the pending length and empties the output
// register; the history RAM is not cleared and needs no start-up time.
// When result_stall is high the output register holds its word, the packer
// fills up behind it and the copy pauses until the receiver takes the word.
// ----------------------------------------------------------------------------
module lz77_history_copy_decoder #(
    parameter int WINDOW_SIZE      = lz77hc_pkg::WINDOW_SIZE_DEF,
    parameter int MAX_LENGTH       = lz77hc_pkg::MAX_LENGTH_DEF,
    parameter int BYTES_PER_RESULT = lz77hc_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     code_valid,
    output logic                     code_stall,
    input  lz77hc_pkg::code_word_t   code,
    output logic                     result_valid,
    input  logic                     result_stall,
    output lz77hc_pkg::result_word_t result
);

    localparam int AW = $clog2(WINDOW_SIZE);

    lz77hc_pkg::pack_credit_t credit;
    lz77hc_pkg::push_t        push;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [7:0]               ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [7:0]               ram_rdata;

    lz77hc_ctrl #(
        .WINDOW_SIZE      (WINDOW_SIZE),
        .MAX_LENGTH       (MAX_LENGTH),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code       (code),
        .code_stall (code_stall),
        .credit     (credit),
        .push       (push),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    lz77hc_hist_ram #(
        .DEPTH (WINDOW_SIZE)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lz77hc_packer #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .credit       (credit),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== design/lz77hc_checker.sv =====
// ----------------------------------------------------------------------------
// LZ77 history-copy decoder port checker
// Checks the result channel and the literal handshake of the decoder over time from its ports.
// ----------------------------------------------------------------------------
`include "lz77_history_copy_decoder_assert.svh"

module lz77hc_checker #(
    parameter int BYTES_PER_RESULT = lz77hc_pkg::BYTES_PER_RESULT_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     code_valid,
    input logic                     code_stall,
    input lz77hc_pkg::code_word_t   code,
    input logic                     result_valid,
    input logic                     result_stall,
    input lz77hc_pkg::result_word_t result
);

    localparam int CW = lz77hc_pkg::COUNT_W;

    // A stalled word stays in place.
    `LZ77HC_ASSERT_NEXT(a_result_hold, clk, rst_n,
        result_valid && result_stall,
        result_valid && $stable(result), "stalled result word changed")

    // Error words carry no bytes.
    `LZ77HC_ASSERT_IMP(a_err_word, clk, rst_n,
        result_valid && (result.status != lz77hc_pkg::STATUS_OK),
        (result.byte_count == '0) && (result.data == '0), "error word with bytes")

    // Data words hold between one and BYTES_PER_RESULT bytes.
    `LZ77HC_ASSERT_IMP(a_ok_count, clk, rst_n,
        result_valid && (result.status == lz77hc_pkg::STATUS_OK),
        (result.byte_count != '0) && (result.byte_count <= CW'(BYTES_PER_RESULT)),
        "data word byte count out of range")

    // Only the final word of a code may be partly filled.
    `LZ77HC_ASSERT_IMP(a_partial_last, clk, rst_n,
        result_valid && (result.status == lz77hc_pkg::STATUS_OK)
            && (result.byte_count < CW'(BYTES_PER_RESULT)),
        result.last, "partial data word not marked last")

    // A taken literal always raises code_stall while its literal state is worked.
    `LZ77HC_ASSERT_NEXT(a_lit_busy, clk, rst_n,
        code_valid && !code_stall && (code.mode == lz77hc_pkg::MODE_LIT),
        code_stall, "literal code taken without a second cycle")

endmodule

bind lz77_history_copy_decoder lz77hc_checker #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code         (code),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
